// ----- src/urv_pkg.sv -----
// ----------------------------------------------------------------------------
// urv_pkg: shared types and constants for the ultrasonic range vote block
// Transfer payloads, the register map and the frame status handed between
// the frame sequencer and the vote unit.
// ----------------------------------------------------------------------------
package urv_pkg;

  // Default width of the near-bit vote window
  localparam int unsigned WindowLenDef = 10;

  // Field widths
  localparam int unsigned DistW   = 15;
  localparam int unsigned CountW  = 6;
  localparam int unsigned PhaseW  = 6;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned VoteW   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Echo count to distance scale
  localparam logic [DistW-1:0] SpeedFactor = DistW'(340);
  localparam logic [CountW-1:0] CountMax   = '1;

  // Register reset values
  localparam logic [ThreshW-1:0] NearThresholdRst = ThreshW'(700);
  localparam logic [VoteW-1:0]   VoteMinRst       = VoteW'(5);
  localparam logic [PhaseW-1:0]  FrameLengthRst   = PhaseW'(20);

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    CfgNearThreshold = 2'd0,
    CfgVoteMin       = 2'd1,
    CfgFrameLength   = 2'd2
  } cfg_idx_e;

  // Input transfer: echo levels at one timer tick
  typedef struct packed {
    logic echo_a;
    logic echo_b;
  } urv_in_t;

  // Output transfer: status after one timer tick
  typedef struct packed {
    logic             trigger;
    logic [DistW-1:0] distance_a;
    logic [DistW-1:0] distance_b;
    logic             obstacle;
    logic             measured;
  } urv_out_t;

  // Frame sequencer status for the current tick (next-state values)
  typedef struct packed {
    logic             trigger;
    logic [DistW-1:0] distance_a;
    logic [DistW-1:0] distance_b;
    logic             measured;
  } urv_frame_t;

endpackage

// ----- src/urv_frame.sv -----
// ----------------------------------------------------------------------------
// urv_frame: tick phase sequencer and echo counters
// Runs the frame phase, drives the trigger, counts echo ticks per sensor and
// scales the counts into distances on the last phase of a frame.
// ----------------------------------------------------------------------------
module urv_frame (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  urv_pkg::urv_in_t              echo_i,
  input  logic [urv_pkg::PhaseW-1:0]    frame_length_i,
  output urv_pkg::urv_frame_t           frame_o
);
  import urv_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW-1:0] count_a_q, count_a_d;
  logic [CountW-1:0] count_b_q, count_b_d;
  logic              trigger_q, trigger_d;
  logic [DistW-1:0]  dist_a_q, dist_a_d;
  logic [DistW-1:0]  dist_b_q, dist_b_d;
  logic [PhaseW-1:0] last_phase;
  logic              measure;

  // Last phase wraps: a frame length of zero gives a 64-tick frame
  assign last_phase = frame_length_i - PhaseW'(1);

  // Phase actions for one tick
  always_comb begin
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    trigger_d = trigger_q;
    measure   = 1'b0;
    if (phase_q == '0) begin
      trigger_d = 1'b1;
      count_a_d = '0;
      count_b_d = '0;
    end else begin
      // saturating echo counters
      if (echo_i.echo_a && (count_a_q != CountMax)) count_a_d = count_a_q + CountW'(1);
      if (echo_i.echo_b && (count_b_q != CountMax)) count_b_d = count_b_q + CountW'(1);
      if (phase_q == PhaseW'(1)) begin
        trigger_d = 1'b0;
      end else if (phase_q == last_phase) begin
        measure = 1'b1;
      end
    end
  end

  // Distance scaling, only taken on a measurement tick
  assign dist_a_d = measure ? DistW'(DistW'(count_a_d) * SpeedFactor) : dist_a_q;
  assign dist_b_d = measure ? DistW'(DistW'(count_b_d) * SpeedFactor) : dist_b_q;

  // Wrap at or past the last phase (covers a frame shortened mid-frame)
  assign phase_d = (phase_q >= last_phase) ? '0 : phase_q + PhaseW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      count_a_q <= '0;
      count_b_q <= '0;
      trigger_q <= 1'b0;
      dist_a_q  <= '0;
      dist_b_q  <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_a_q <= count_a_d;
      count_b_q <= count_b_d;
      trigger_q <= trigger_d;
      dist_a_q  <= dist_a_d;
      dist_b_q  <= dist_b_d;
    end
  end

  assign frame_o.trigger    = trigger_d;
  assign frame_o.distance_a = dist_a_d;
  assign frame_o.distance_b = dist_b_d;
  assign frame_o.measured   = measure;

endmodule

// ----- src/urv_vote.sv -----
// ----------------------------------------------------------------------------
// urv_vote: near-bit window and obstacle vote
// Shifts one near bit per sensor into a shared window on each measurement
// and sets the obstacle flag when the window holds enough ones.
// ----------------------------------------------------------------------------
module urv_vote #(
  parameter int unsigned WINDOW_LEN = urv_pkg::WindowLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  urv_pkg::urv_frame_t           frame_i,
  input  logic [urv_pkg::ThreshW-1:0]   near_threshold_i,
  input  logic [urv_pkg::VoteW-1:0]     vote_min_i,
  output logic                          obstacle_o
);
  import urv_pkg::*;

  localparam int unsigned OnesW = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CmpW  = (OnesW > VoteW) ? OnesW : VoteW;

  logic [WINDOW_LEN-1:0] window_q, window_d;
  logic [WINDOW_LEN+1:0] window_shift;
  logic                  obstacle_q, obstacle_d;
  logic                  near_a, near_b;
  logic [OnesW-1:0]      ones;

  // Near test per sensor
  assign near_a = {1'b0, frame_i.distance_a} < near_threshold_i;
  assign near_b = {1'b0, frame_i.distance_b} < near_threshold_i;

  // Sensor A enters first, then sensor B
  assign window_shift = {window_q, near_a, near_b};
  assign window_d     = frame_i.measured ? window_shift[WINDOW_LEN-1:0] : window_q;

  // Population count of the updated window
  always_comb begin
    ones = '0;
    for (int unsigned i = 0; i < WINDOW_LEN; i++) begin
      ones = ones + OnesW'(window_d[i]);
    end
  end

  assign obstacle_d = frame_i.measured ? (CmpW'(ones) >= CmpW'(vote_min_i)) : obstacle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      obstacle_q <= 1'b0;
    end else if (step_i) begin
      window_q   <= window_d;
      obstacle_q <= obstacle_d;
    end
  end

  assign obstacle_o = obstacle_d;

endmodule

// ----- src/ultrasonic_range_vote.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_range_vote: two-sensor ultrasonic ranging with a majority vote
// Top level: configuration registers, input and result registers.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transfer is one timer tick carrying both echo levels. Every
//   tick yields exactly one output transfer with the trigger level, the
//   latest distances, the obstacle flag and a measured strobe.
//   The path is an input register, the phase/counter and vote logic, then
//   the result register. One tick is accepted every cycle while in_stall_o
//   is low.
//   When out_stall_i holds a result, the input register is stalled behind it
//   only if it also holds a tick, so one more tick is taken while a result
//   waits. A stalled result holds its payload.
//   Configuration: cfg_index_i selects near threshold (0), vote minimum (1)
//   or frame length (2); other indexes are ignored. cfg_ready_o is always
//   high. Write only while no ticks are in flight.
//   Reset clears the phase, counters, window, distances and both pipeline
//   valid bits, and loads the register defaults (700, 5, 20).
// ----------------------------------------------------------------------------
module ultrasonic_range_vote #(
  parameter int unsigned WINDOW_LEN = urv_pkg::WindowLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  urv_pkg::urv_in_t              in_data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output urv_pkg::urv_out_t             out_data_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [urv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [urv_pkg::CfgDataW-1:0]  cfg_data_i
);
  import urv_pkg::*;

  logic [ThreshW-1:0] near_threshold_q;
  logic [VoteW-1:0]   vote_min_q;
  logic [PhaseW-1:0]  frame_length_q;

  logic       in_valid_q;
  urv_in_t    in_data_q;
  logic       out_valid_q;
  urv_out_t   out_data_q;
  logic       out_free;
  logic       step;
  urv_frame_t frame;
  logic       obstacle;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_threshold_q <= NearThresholdRst;
      vote_min_q       <= VoteMinRst;
      frame_length_q   <= FrameLengthRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNearThreshold: near_threshold_q <= cfg_data_i[ThreshW-1:0];
        CfgVoteMin:       vote_min_q       <= cfg_data_i[VoteW-1:0];
        CfgFrameLength:   frame_length_q   <= cfg_data_i[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // Phase sequencer and echo counters
  urv_frame u_frame (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .echo_i         (in_data_q),
    .frame_length_i (frame_length_q),
    .frame_o        (frame)
  );

  // Near window and obstacle vote
  urv_vote #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_vote (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .frame_i          (frame),
    .near_threshold_i (near_threshold_q),
    .vote_min_i       (vote_min_q),
    .obstacle_o       (obstacle)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q.trigger    <= frame.trigger;
      out_data_q.distance_a <= frame.distance_a;
      out_data_q.distance_b <= frame.distance_b;
      out_data_q.obstacle   <= obstacle;
      out_data_q.measured   <= frame.measured;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A measurement is never taken while the trigger is still driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.measured |-> !out_data_o.trigger)
    else $error("measurement reported with trigger high");

  // The input side only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A taken result with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !in_valid_q |=> !out_valid_o)
    else $error("result repeated after transfer");

endmodule

// ----- test/urv_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urv_tb_pkg: scoreboard for the ultrasonic range vote testbench
// Tracks the frame phase, echo counters, near window and registers of the
// block, predicts the status of every accepted tick and checks the results
// in order against those predictions.
// ----------------------------------------------------------------------------
package urv_tb_pkg;
  import urv_pkg::*;

  // Register index with no register behind it
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  class range_vote_scoreboard;
    // register copies
    logic [ThreshW-1:0]      near_thr;
    logic [VoteW-1:0]        vote_min;
    logic [PhaseW-1:0]       frame_len;
    // block state copies
    logic [PhaseW-1:0]       phase;
    logic [CountW-1:0]       cnt_a;
    logic [CountW-1:0]       cnt_b;
    logic                    trig;
    logic [WindowLenDef-1:0] near_win;
    logic                    obst;
    logic [DistW-1:0]        dist_a;
    logic [DistW-1:0]        dist_b;
    // predicted status, oldest first
    urv_out_t                status_q[$];
    int unsigned             errors;

    function new();
      near_thr  = NearThresholdRst;
      vote_min  = VoteMinRst;
      frame_len = FrameLengthRst;
      phase     = '0;
      cnt_a     = '0;
      cnt_b     = '0;
      trig      = 1'b0;
      near_win  = '0;
      obst      = 1'b0;
      dist_a    = '0;
      dist_b    = '0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgNearThreshold: near_thr  = val[ThreshW-1:0];
        CfgVoteMin:       vote_min  = val[VoteW-1:0];
        CfgFrameLength:   frame_len = val[PhaseW-1:0];
        default: ;
      endcase
    endfunction

    // Advance one timer tick and queue the status it produces
    function void note_tick(urv_in_t tick);
      logic [PhaseW-1:0] last_ph;
      urv_out_t          st;
      last_ph     = frame_len - 1'b1;  // frame length zero gives a 64-tick frame
      st.measured = 1'b0;
      if (phase == '0) begin
        trig  = 1'b1;
        cnt_a = '0;
        cnt_b = '0;
      end else begin
        // counters saturate
        if (tick.echo_a && cnt_a != CountMax) cnt_a = cnt_a + 1'b1;
        if (tick.echo_b && cnt_b != CountMax) cnt_b = cnt_b + 1'b1;
        if (phase == PhaseW'(1)) begin
          trig = 1'b0;
        end else if (phase == last_ph) begin
          dist_a   = DistW'(32'(cnt_a) * 32'(SpeedFactor));
          dist_b   = DistW'(32'(cnt_b) * 32'(SpeedFactor));
          near_win = {near_win[WindowLenDef-2:0], (16'(dist_a) < near_thr)};
          near_win = {near_win[WindowLenDef-2:0], (16'(dist_b) < near_thr)};
          obst     = ($countones(near_win) >= int'(vote_min));
          st.measured = 1'b1;
        end
      end
      // a phase past the last one (frame shortened mid-frame) wraps at once
      phase = (phase >= last_ph) ? '0 : phase + 1'b1;

      st.trigger    = trig;
      st.distance_a = dist_a;
      st.distance_b = dist_b;
      st.obstacle   = obst;
      status_q.push_back(st);
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_status(urv_out_t got);
      urv_out_t exp_st;
      if (status_q.size() == 0) begin
        $error("result transfer with no tick outstanding");
        errors++;
        return;
      end
      exp_st = status_q.pop_front();
      cmp_field("trigger",    32'(exp_st.trigger),    32'(got.trigger));
      cmp_field("distance_a", 32'(exp_st.distance_a), 32'(got.distance_a));
      cmp_field("distance_b", 32'(exp_st.distance_b), 32'(got.distance_b));
      cmp_field("obstacle",   32'(exp_st.obstacle),   32'(got.obstacle));
      cmp_field("measured",   32'(exp_st.measured),   32'(got.measured));
    endfunction
  endclass

endpackage

// ----- test/tb_ultrasonic_range_vote.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_vote: testbench for the ultrasonic range vote block
// Drives timer ticks with random echo levels and random gaps, stalls the
// result side at random (once for a long stretch), reprograms the registers
// between bursts and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_vote;
  import urv_pkg::*;
  import urv_tb_pkg::*;

  localparam int unsigned RandomTicks   = 1250;
  localparam int unsigned HoldCycles    = 90;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  urv_in_t             in_data    = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  urv_out_t            out_data;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  range_vote_scoreboard sb = new();

  bit          burst_mode = 1'b0;  // no idling on either side
  bit          hold_req   = 1'b0;  // receiver holds off for a long stretch
  int unsigned ticks_sent = 0;
  int unsigned idle_cycles = 0;

  ultrasonic_range_vote u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock and reset
  always #6 clk = ~clk;

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Transfer monitor
  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_tick(in_data);
    if (out_valid && !out_stall) sb.check_status(out_data);
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result receiver: random stall before each transfer
  initial begin : receiver
    int unsigned gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        gap      = HoldCycles;
        hold_req = 1'b0;
      end else begin
        gap = burst_mode ? 0 : $urandom_range(0, 19);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // One tick transfer; valid stays high for a following call
  task automatic send_tick(urv_in_t tick);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk); while (!(in_valid && !in_stall));
    ticks_sent++;
  endtask

  // Ticks with echoes high at the given percentage
  task automatic send_ticks(int unsigned n, int unsigned pct);
    urv_in_t tick;
    repeat (n) begin
      tick.echo_a = ($urandom_range(0, 99) < pct);
      tick.echo_b = ($urandom_range(0, 99) < pct);
      send_tick(tick);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Register write; valid is left high for back-to-back writes
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(logic [CfgDataW-1:0] thr, logic [CfgDataW-1:0] vote,
                          logic [CfgDataW-1:0] frame);
    write_reg(CfgNearThreshold, thr);
    write_reg(CfgVoteMin, vote);
    write_reg(CfgFrameLength, frame);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned         ph_idx;
    int unsigned         pct;
    logic [CfgDataW-1:0] val;
    bit                  wrote;
    do @(posedge clk); while (!rst_n);

    // short frames, everything near, vote minimum zero
    set_regs(16'hFFFF, 16'd0, 16'd3);
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b0, echo_b: 1'b0});
    send_tick('{echo_a: 1'b1, echo_b: 1'b0});
    send_tick('{echo_a: 1'b0, echo_b: 1'b1});
    drain();
    // one-tick frame, nothing near, vote minimum above window; upper bits set
    set_regs(16'h0000, 16'hFFFF, 16'hFFC1);
    send_tick('{echo_a: 1'b1, echo_b: 1'b0});
    send_tick('{echo_a: 1'b0, echo_b: 1'b1});
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    drain();
    // two-tick frame never measures
    set_regs(16'd700, 16'd10, 16'd2);
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b0, echo_b: 1'b0});
    drain();
    // distance equal to threshold is not near
    set_regs(16'd680, 16'd1, 16'd3);
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    send_tick('{echo_a: 1'b0, echo_b: 1'b1});
    send_tick('{echo_a: 1'b0, echo_b: 1'b1});
    send_tick('{echo_a: 1'b0, echo_b: 1'b1});
    drain();
    // unmapped index is ignored; frame length zero is a 64-tick frame
    write_reg(CfgSpare, 16'h0005);
    write_reg(CfgFrameLength, 16'd0);
    cfg_valid <= 1'b0;
    repeat (5) send_tick('{echo_a: 1'b1, echo_b: 1'b1});
    drain();

    // Random bursts with register changes between them
    ticks_sent = 0;
    ph_idx     = 0;
    while (ticks_sent < RandomTicks) begin
      ph_idx++;
      wrote = 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 4))
          0:       val = 16'h0000;
          1:       val = 16'hFFFF;
          2:       val = 16'(340 * $urandom_range(0, 63));
          3:       val = 16'(340 * $urandom_range(0, 63) + 1);
          default: val = 16'($urandom);
        endcase
        write_reg(CfgNearThreshold, val);
        wrote = 1'b1;
      end
      if ($urandom_range(0, 1) == 1) begin
        val = 16'($urandom);
        val[VoteW-1:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(1, 10));
        write_reg(CfgVoteMin, val);
        wrote = 1'b1;
      end
      if ($urandom_range(0, 1) == 1 || ph_idx == 2) begin
        val = 16'($urandom);
        case ($urandom_range(0, 7))
          0:       val[PhaseW-1:0] = 6'd63;
          1:       val[PhaseW-1:0] = 6'($urandom_range(0, 2));
          2:       val[PhaseW-1:0] = 6'($urandom);
          default: val[PhaseW-1:0] = 6'($urandom_range(3, 24));
        endcase
        if (ph_idx == 2) val[PhaseW-1:0] = 6'd63;
        write_reg(CfgFrameLength, val);
        wrote = 1'b1;
      end
      if (wrote) cfg_valid <= 1'b0;

      burst_mode = ($urandom_range(0, 3) == 0);
      // long receiver hold-off while ticks keep coming
      if (ph_idx == 4) begin
        burst_mode = 1'b1;
        hold_req   = 1'b1;
      end
      case ($urandom_range(0, 5))
        0:       pct = 0;
        1:       pct = 100;
        2:       pct = 25;
        3:       pct = 75;
        default: pct = $urandom_range(0, 100);
      endcase
      send_ticks($urandom_range(20, 100), pct);
      drain();
    end

    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/urv_pkg.sv
src/urv_frame.sv
src/urv_vote.sv
src/ultrasonic_range_vote.sv
test/urv_tb_pkg.sv
test/tb_ultrasonic_range_vote.sv
